/* sv/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants of the lru key-value cache: beat layouts,
// broadcast and chain structs of the cell row, command codes and fsm states
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int KEY_W       = 32;
   localparam int DATA_W      = 32;
   localparam int CSR_W       = 5;
   localparam int AGE_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W       = (CSR_W > OCC_W) ? CSR_W : OCC_W;

   localparam logic [CSR_W-1:0]  CAPACITY_RESET = CSR_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE     = '1;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } lkvc_state_type;

   typedef struct packed {
      logic                     command;
      logic signed [KEY_W-1:0]  key;
      logic signed [DATA_W-1:0] put_value;
   } lkvc_req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } lkvc_rsp_type;

   // broadcast to every cell during the compare cycle
   typedef struct packed {
      logic             en;
      logic [KEY_W-1:0] key;
      logic [AGE_W-1:0] evict_age;
   } lkvc_look_type;

   // broadcast to every cell during the write-back cycle
   typedef struct packed {
      logic              en;
      logic              hit;
      logic              use_free;
      logic              put;
      logic [AGE_W-1:0]  touch_age;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] value;
   } lkvc_upd_type;

   // handed from each cell to its higher-numbered neighbour
   typedef struct packed {
      logic              hit_seen;
      logic              free_seen;
      logic [DATA_W-1:0] hit_data;
      logic [AGE_W-1:0]  hit_age;
   } lkvc_chain_type;

endpackage

/* sv/lkvc_cell.sv */
// ----------------------------------------------------------------------------
// lkvc_cell
// one entry of the cache: key, data, recency rank and valid mark, with its
// own compare and its link in the priority chain of the row
// ----------------------------------------------------------------------------
module lkvc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  lkvc_pkg::lkvc_look_type look,
   input  lkvc_pkg::lkvc_upd_type  upd,
   input  lkvc_pkg::lkvc_chain_type chain_in,
   output lkvc_pkg::lkvc_chain_type chain_out,
   output logic                    valid
);
   import lkvc_pkg::*;

   logic              valid_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [DATA_W-1:0] data_ff;
   logic [AGE_W-1:0]  age_ff;
   logic              hit_sel_ff;
   logic              free_sel_ff;
   logic              old_sel_ff;

   logic match;
   logic hit_here;
   logic free_here;
   logic old_here;
   logic target;
   logic touch_all;

   assign valid = valid_ff;

   // lowest matching cell and lowest empty cell win along the chain
   assign match     = valid_ff && (key_ff == look.key);
   assign hit_here  = match && !chain_in.hit_seen;
   assign free_here = !valid_ff && !chain_in.free_seen;
   assign old_here  = valid_ff && (age_ff == look.evict_age);

   always_comb begin
      chain_out.hit_seen  = chain_in.hit_seen | match;
      chain_out.free_seen = chain_in.free_seen | !valid_ff;
      chain_out.hit_data  = chain_in.hit_data | (hit_here ? data_ff : '0);
      chain_out.hit_age   = chain_in.hit_age | (hit_here ? age_ff : '0);
   end

   assign target    = upd.hit ? hit_sel_ff : (upd.use_free ? free_sel_ff : old_sel_ff);
   assign touch_all = !upd.hit && upd.use_free;

   always_ff @(posedge clock) begin
      if (look.en) begin
         hit_sel_ff  <= hit_here;
         free_sel_ff <= free_here;
         old_sel_ff  <= old_here;
      end
      if (upd.en) begin
         if (target) begin
            key_ff <= upd.key;
            age_ff <= '0;
            if (upd.put) begin
               data_ff <= upd.value;
            end
         end else if (valid_ff && (touch_all || (age_ff < upd.touch_age))) begin
            age_ff <= age_ff + AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (upd.en && target) begin
         valid_ff <= 1'b1;
      end
   end

endmodule

/* sv/lru_key_value_cache_unit.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative key-value cache with least-recently-used replacement,
// built as a row of entry cells linked by a priority chain
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               beat
//   req       in          req_valid / req_stall   lkvc_req_type (command, key, put_value)
//   rsp       out         rsp_valid / rsp_stall   lkvc_rsp_type (hit, read_value)
//   csr       in          csr_write               capacity, 5 bits
//
// each request passes through accept, compare across the cell row, write back
// the rate is set by the two passes through the cell chain (compare, then update)
// the response sits in an output register; write back waits while it is stalled
// a new request is taken once the previous one has been written back
// synchronous reset clears all valid marks, occupancy and capacity (to 16)
//
module lru_key_value_cache_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lkvc_pkg::lkvc_req_type      req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lkvc_pkg::lkvc_rsp_type      rsp_payload,
   input  logic                        csr_write,
   input  logic [lkvc_pkg::CSR_W-1:0]  csr_wdata
);
   import lkvc_pkg::*;

   lkvc_state_type    state_ff, state_in;
   lkvc_req_type      req_ff;
   logic [CSR_W-1:0]  capacity_ff;
   logic [OCC_W-1:0]  occ_ff;
   logic              hit_ff;
   logic [DATA_W-1:0] hit_data_ff;
   logic [AGE_W-1:0]  hit_age_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   lkvc_rsp_type      rsp_payload_ff;

   logic              req_accept;
   logic              done;
   logic              is_put;
   logic              use_free;
   logic [CMP_W-1:0]  cap_wide;
   logic [CMP_W-1:0]  cap_eff;
   logic [AGE_W-1:0]  evict_age;
   lkvc_look_type     look;
   lkvc_upd_type      upd;
   lkvc_chain_type    chain [MAX_ENTRIES+1];
   logic [MAX_ENTRIES-1:0] valid_vec;

   // ---------------------------------------------------------------- handshake
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign done        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign is_put      = (req_ff.command == CMD_PUT);

   // ---------------------------------------------------------------- capacity
   // zero acts as one, anything above the row size acts as the row size
   assign cap_wide = CMP_W'(capacity_ff);
   always_comb begin
      if (cap_wide == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_wide > CMP_W'(MAX_ENTRIES)) begin
         cap_eff = CMP_W'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_wide;
      end
   end

   assign use_free  = CMP_W'(occ_ff) < cap_eff;
   // valid entries hold ranks 0 .. occupancy-1, so the oldest one has the top rank
   assign evict_age = AGE_W'(occ_ff - OCC_W'(1));

   // ---------------------------------------------------------------- broadcasts
   always_comb begin
      look.en        = (state_ff == ST_LOOKUP);
      look.key       = req_ff.key;
      look.evict_age = evict_age;

      upd.en        = (state_ff == ST_UPDATE) && done && (is_put || hit_ff);
      upd.hit       = hit_ff;
      upd.use_free  = use_free;
      upd.put       = is_put;
      upd.touch_age = hit_ff ? hit_age_ff : evict_age;
      upd.key       = req_ff.key;
      upd.value     = req_ff.put_value;
   end

   // ---------------------------------------------------------------- cell row
   assign chain[0] = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      lkvc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .look      (look),
         .upd       (upd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .valid     (valid_vec[i])
      );
   end

   // ---------------------------------------------------------------- control fsm
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAPACITY_RESET;
         occ_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            capacity_ff <= csr_wdata;
         end
         // a put miss into an empty slot grows occupancy, an eviction does not
         if (upd.en && is_put && !hit_ff && use_free) begin
            occ_ff <= occ_ff + OCC_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------- payload regs
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_payload;
      end
      if (state_ff == ST_LOOKUP) begin
         hit_ff      <= chain[MAX_ENTRIES].hit_seen;
         hit_data_ff <= chain[MAX_ENTRIES].hit_data;
         hit_age_ff  <= chain[MAX_ENTRIES].hit_age;
      end
      if ((state_ff == ST_UPDATE) && done) begin
         rsp_payload_ff.hit <= hit_ff;
         if (is_put) begin
            rsp_payload_ff.read_value <= req_ff.put_value;
         end else if (hit_ff) begin
            rsp_payload_ff.read_value <= hit_data_ff;
         end else begin
            rsp_payload_ff.read_value <= MISS_VALUE;
         end
      end
   end

`ifndef NO_ASSERTIONS
   // occupancy tracks the number of valid marks in the row
   a_occ_count : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(occ_ff))
      else $error("occupancy does not match valid marks");

   a_occ_limit : assert property (@(posedge clock) disable iff (reset)
      int'(occ_ff) <= MAX_ENTRIES)
      else $error("occupancy above row size");

   a_lookup_next : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |=> (state_ff == ST_UPDATE))
      else $error("compare cycle not followed by write back");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside write back");
`endif

endmodule

/* tb/tb_lru_key_value_cache_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// self-checking bench for the lru key-value cache: a short table of directed
// beats, then randomised get/put traffic over small key pools at several
// capacity settings, each response checked against a behavioural lru model
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;

   import lkvc_pkg::*;

   // one directed step: either a request beat or a capacity write
   typedef struct packed {
      logic         csr_row;     // capacity write, value in put_value
      logic         command;
      logic [31:0]  key;
      logic [31:0]  put_value;
      logic         typed;       // expected response given in the row
      lkvc_rsp_type want;
   } plan_row_type;

   localparam int PLAN_ROWS = 24;
   localparam int POOL_MAX  = MAX_ENTRIES + 4;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   lkvc_req_type        req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   lkvc_rsp_type        rsp_payload;
   logic                csr_write   = 1'b0;
   logic [CSR_W-1:0]    csr_wdata   = '0;

   // behavioural copy of the cache contents and the capacity register
   logic                lru_valid [MAX_ENTRIES] = '{default: 1'b0};
   logic [KEY_W-1:0]    lru_key   [MAX_ENTRIES];
   logic [DATA_W-1:0]   lru_data  [MAX_ENTRIES];
   int unsigned         lru_age   [MAX_ENTRIES] = '{default: 0};
   int unsigned         lru_fill     = 0;
   logic [CSR_W-1:0]    lru_capacity = CAPACITY_RESET;

   lkvc_rsp_type        pending_rsp [$];
   int                  mismatch_count = 0;

   // traffic shaping
   bit                  calm       = 1'b0;
   int                  burst_left = 0;
   int                  stall_run  = 0;
   int                  flow_run   = 0;

   // directed part: extremes of key and value, both commands, update in place,
   // a stored all-ones value read back with hit set, capacity lowered below
   // occupancy, capacity of zero and capacities above the entry count
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{1'b0, CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, MISS_VALUE}},
      '{1'b0, CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 32'h8000_0000}},
      '{1'b0, CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, 32'h7FFF_FFFF}},
      '{1'b0, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000}},
      '{1'b0, CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'hFFFF_FFFF}},
      '{1'b0, CMD_GET, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1, '{1'b1, 32'hFFFF_FFFF}},
      '{1'b0, CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000}},
      '{1'b0, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
      '{1'b0, CMD_PUT, 32'h0000_0000, 32'h5555_5555, 1'b0, '0},
      '{1'b0, CMD_PUT, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, '0},
      '{1'b0, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
      '{1'b1, CMD_GET, 32'h0000_0000, 32'd2,         1'b0, '0},
      '{1'b0, CMD_PUT, 32'h1234_5678, 32'h0000_0001, 1'b0, '0},
      '{1'b0, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
      '{1'b0, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
      '{1'b1, CMD_GET, 32'h0000_0000, 32'd0,         1'b0, '0},
      '{1'b0, CMD_PUT, 32'h0000_0001, 32'hFFFF_0000, 1'b0, '0},
      '{1'b0, CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
      '{1'b0, CMD_GET, 32'h1234_5678, 32'h0000_0000, 1'b0, '0},
      '{1'b1, CMD_GET, 32'h0000_0000, 32'd31,        1'b0, '0},
      '{1'b0, CMD_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, '0},
      '{1'b0, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{1'b1, CMD_GET, 32'h0000_0000, 32'd17,        1'b0, '0},
      '{1'b0, CMD_PUT, 32'hDEAD_0001, 32'h0000_FFFF, 1'b0, '0}
   };

   // capacities for the first eight random phases; the last two phases draw theirs at random
   logic [CSR_W-1:0] phase_caps [8] = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd16, 5'd7, 5'd3};
   logic [31:0]      edge_keys  [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

   lru_key_value_cache_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // make slot s most recent; entries newer than it age by one, and an empty
   // slot counts as older than every valid entry
   function automatic void promote(int s);
      bit          was_held;
      int unsigned old_age;
      was_held = lru_valid[s];
      old_age  = lru_age[s];
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (i != s && lru_valid[i] && (!was_held || lru_age[i] < old_age))
            lru_age[i]++;
      end
      lru_age[s] = 0;
   endfunction

   // apply one request beat to the cache copy and return its response
   function automatic lkvc_rsp_type predict_access(lkvc_req_type beat);
      lkvc_rsp_type r;
      int           s;
      bit           found;
      int unsigned  limit;
      limit = (lru_capacity == 0) ? 1 :
              (lru_capacity > MAX_ENTRIES) ? MAX_ENTRIES : lru_capacity;
      s = -1;
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (s < 0 && lru_valid[i] && lru_key[i] == beat.key) s = i;

      if (beat.command == CMD_GET) begin
         if (s >= 0) begin
            promote(s);
            r.hit        = 1'b1;
            r.read_value = lru_data[s];
         end else begin
            r.hit        = 1'b0;
            r.read_value = MISS_VALUE;
         end
         return r;
      end

      r.hit        = (s >= 0);
      r.read_value = beat.put_value;
      if (s >= 0) begin
         lru_data[s] = beat.put_value;
         promote(s);
         return r;
      end

      // insert: free slot while below capacity, else reuse the oldest entry
      if (lru_fill < limit)
         for (int i = 0; i < MAX_ENTRIES; i++)
            if (s < 0 && !lru_valid[i]) s = i;
      if (s < 0) begin
         found = 1'b0;
         s     = 0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (lru_valid[i] && (!found || lru_age[i] > lru_age[s])) begin
               s     = i;
               found = 1'b1;
            end
         end
         if (!lru_valid[s]) lru_fill++;
      end else begin
         lru_fill++;
      end
      promote(s);
      lru_valid[s] = 1'b1;
      lru_key[s]   = beat.key;
      lru_data[s]  = beat.put_value;
      return r;
   endfunction

   // present one beat, hold it until taken, then log its expected response;
   // bursts of random length are broken by random gaps unless traffic is calm
   task automatic drive_beat(input lkvc_req_type beat, input bit typed,
                             input lkvc_rsp_type want);
      lkvc_rsp_type predicted;
      if (!calm && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end else if (burst_left != 0) begin
         burst_left--;
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      predicted = predict_access(beat);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   // capacity only changes once every response is back and the cache is idle
   task automatic write_capacity(input logic [CSR_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write    <= 1'b0;
      lru_capacity  = value;
   endtask

   // receiver: runs of free flow alternate with runs of stall
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else if (flow_run > 0) begin
         rsp_stall <= 1'b0;
         flow_run--;
      end else begin
         rsp_stall <= 1'b0;
         flow_run  = $urandom_range(0, 12);
         stall_run = $urandom_range(1, 8);
      end
   end

   // response checker, oldest expectation first
   always @(posedge clock) begin
      lkvc_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected response beat: hit %0b value %h",
                        rsp_payload.hit, rsp_payload.read_value);
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.hit !== want.hit ||
                rsp_payload.read_value !== want.read_value) begin
               if (mismatch_count < 10)
                  $display("response mismatch: expected hit %0b value %h, got hit %0b value %h",
                           want.hit, want.read_value, rsp_payload.hit,
                           rsp_payload.read_value);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      lkvc_req_type     beat;
      logic [CSR_W-1:0] cap;
      logic [31:0]      key_pool [POOL_MAX];
      int               pool_size;
      int               waited;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table, capacity at its reset value until the first write row
      foreach (directed_plan[r]) begin
         if (directed_plan[r].csr_row) begin
            write_capacity(directed_plan[r].put_value[CSR_W-1:0]);
         end else begin
            beat.command   = directed_plan[r].command;
            beat.key       = directed_plan[r].key;
            beat.put_value = directed_plan[r].put_value;
            drive_beat(beat, directed_plan[r].typed, directed_plan[r].want);
         end
      end

      // random phases: a key pool a little larger than the capacity keeps
      // hits, updates and evictions frequent; a quarter of keys are fresh
      for (int p = 0; p < 10; p++) begin
         cap = (p < 8) ? phase_caps[p] : CSR_W'($urandom_range(0, 31));
         write_capacity(cap);
         calm      = (p == 2) || (p == 6);
         pool_size = ((cap > MAX_ENTRIES) ? MAX_ENTRIES : cap) + $urandom_range(1, 4);
         for (int i = 0; i < pool_size; i++)
            key_pool[i] = ($urandom_range(0, 15) == 0) ? edge_keys[$urandom_range(0, 3)]
                                                       : $urandom;
         for (int n = 0; n < 155; n++) begin
            beat.command   = ($urandom_range(0, 1) == 0) ? CMD_GET : CMD_PUT;
            beat.key       = ($urandom_range(0, 3) != 0) ?
                             key_pool[$urandom_range(0, pool_size - 1)] : $urandom;
            beat.put_value = $urandom;
            drive_beat(beat, 1'b0, '0);
         end
      end

      // drain, then allow for the pipe to go quiet
      calm      = 1'b1;
      req_valid <= 1'b0;
      waited    = 0;
      while (pending_rsp.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $display("%0d expected responses never arrived", pending_rsp.size());
         mismatch_count++;
      end

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
